### rtl/skrm_pkg.sv
package skrm_pkg;

    // Report layout
    localparam int unsigned REPORT_LEN = 11;
    localparam int unsigned IDX_W      = $clog2(REPORT_LEN);
    localparam int unsigned KEY_BYTES  = 6;

    localparam logic [IDX_W-1:0] IDX_FIRST  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(REPORT_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_KEYEND = IDX_W'(KEY_BYTES - 1);
    localparam logic [IDX_W-1:0] BYTE_DX    = IDX_W'(6);
    localparam logic [IDX_W-1:0] BYTE_DY    = IDX_W'(7);
    localparam logic [IDX_W-1:0] BYTE_WR    = IDX_W'(8);
    localparam logic [IDX_W-1:0] BYTE_WL    = IDX_W'(9);
    localparam logic [IDX_W-1:0] BYTE_BTN   = IDX_W'(10);

    localparam logic [7:0]  POLL_CHAR  = 8'h73;
    localparam logic [19:0] IDLE_RESET = 20'd100000;

    localparam logic [7:0] BTN_LEFT  = 8'h80;
    localparam logic [7:0] BTN_RIGHT = 8'h40;
    localparam logic [7:0] SAT_POS   = 8'h7F;
    localparam logic [7:0] SAT_NEG   = 8'h81;

    // Request codes
    typedef enum logic [1:0] {
        REQ_LEFT  = 2'd0,
        REQ_RIGHT = 2'd1,
        REQ_SERIAL = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    // Surviving bits per key byte when a half is cleared
    localparam logic [7:0] KEEP_LEFT  [KEY_BYTES] = '{8'h03, 8'hF0, 8'h3F, 8'h03, 8'hF1, 8'hC7};
    localparam logic [7:0] KEEP_RIGHT [KEY_BYTES] = '{8'hFC, 8'h0F, 8'hC0, 8'hFC, 8'h0E, 8'h38};

    // Destination bit (byte * 8 + bit) of each key bit
    localparam logic [5:0] DEST_LEFT [24] = '{
        6'd23, 6'd22, 6'd7,  6'd6,  6'd5,  6'd4,  6'd3,  6'd2,
        6'd29, 6'd28, 6'd27, 6'd26, 6'd11, 6'd10, 6'd9,  6'd8,
        6'd45, 6'd44, 6'd43, 6'd35, 6'd34, 6'd33, 6'd31, 6'd30
    };
    localparam logic [5:0] DEST_RIGHT [24] = '{
        6'd20, 6'd21, 6'd12, 6'd13, 6'd14, 6'd15, 6'd0,  6'd1,
        6'd38, 6'd39, 6'd24, 6'd25, 6'd16, 6'd17, 6'd18, 6'd19,
        6'd40, 6'd41, 6'd42, 6'd46, 6'd47, 6'd32, 6'd36, 6'd37
    };

    // Operation applied by the byte unit during an update sweep
    typedef struct packed {
        logic              clr_left;
        logic              clr_right;
        logic              add_en;
        logic              right;
        logic              button;
        logic [23:0]       keys;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic signed [7:0] dw;
    } alu_op_t;

    // Gather the key bits of one half that land in report byte idx
    function automatic logic [7:0] key_byte(input logic right, input logic [23:0] keys,
                                            input logic [2:0] idx);
        logic [7:0] res;
        logic [5:0] d;
        res = 8'h00;
        for (int k = 0; k < 24; k++)
        begin
            d = right ? DEST_RIGHT[k] : DEST_LEFT[k];
            if (keys[k] && (d[5:3] == idx))
            begin
                res[d[2:0]] = 1'b1;
            end
        end
        return res;
    endfunction

    // Signed add clamped to +/-127
    function automatic logic [7:0] sat_add(input logic signed [7:0] a,
                                           input logic signed [7:0] b);
        logic signed [8:0] s;
        s = {a[7], a} + {b[7], b};
        if (s > 9'sd127)
        begin
            return SAT_POS;
        end
        else if (s < -9'sd127)
        begin
            return SAT_NEG;
        end
        return s[7:0];
    endfunction

endpackage

### rtl/split_keyboard_report_merger.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  req_type key_bits button delta_x delta_y
//                                        delta_wheel rx_byte
// out      output     out_valid/out_stall report_byte last
// cfg      input      cfg_we             cfg_wdata (idle_limit)
//
// A packet, or a tick that expires a half, runs a sweep of the byte unit over all 11
// report bytes, one byte per cycle; a plain tick or other serial byte causes no sweep.
// A poll streams 11 bytes through the output register, one per cycle when out_stall is
// low; out_stall holds the stream. The input stalls while a sweep or a poll runs.
// Reset clears the report and both idle counters and sets idle_limit to 100000.
module split_keyboard_report_merger (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [23:0]       key_bits,
    input  logic              button,
    input  logic signed [7:0] delta_x,
    input  logic signed [7:0] delta_y,
    input  logic signed [7:0] delta_wheel,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        report_byte,
    output logic              last,
    input  logic              cfg_we,
    input  logic [19:0]       cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_UPD  = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    localparam int unsigned IW = skrm_pkg::IDX_W;

    state_t             state_reg, state_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [7:0]         store_reg [skrm_pkg::REPORT_LEN];
    logic [20:0]        left_idle_reg, left_idle_next;
    logic [20:0]        right_idle_reg, right_idle_next;
    logic [19:0]        limit_reg;
    skrm_pkg::alu_op_t  op_reg, op_next;
    logic [7:0]         acc_reg, acc_next;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg;

    logic               in_xfer;
    logic               is_packet;
    logic               is_poll;
    logic               is_tick;
    logic [20:0]        left_inc;
    logic [20:0]        right_inc;
    logic               left_exp;
    logic               right_exp;
    logic [7:0]         cur_byte;
    logic [7:0]         alu_byte;
    logic               out_free;
    logic               load;
    logic [7:0]         chk;
    logic [7:0]         send_byte;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign is_packet = (req_type == skrm_pkg::REQ_LEFT) || (req_type == skrm_pkg::REQ_RIGHT);
    assign is_tick   = (req_type == skrm_pkg::REQ_TICK);
    assign is_poll   = (req_type == skrm_pkg::REQ_SERIAL) && (rx_byte == skrm_pkg::POLL_CHAR);

    // Advance idle counters and test against the limit
    assign left_inc  = left_idle_reg + 21'd1;
    assign right_inc = right_idle_reg + 21'd1;
    assign left_exp  = left_inc > {1'b0, limit_reg};
    assign right_exp = right_inc > {1'b0, limit_reg};

    // Shared byte update unit
    assign cur_byte = store_reg[idx_reg];

    skrm_byte_alu u_alu (
        .op  (op_reg),
        .idx (idx_reg),
        .cur (cur_byte),
        .nxt (alu_byte)
    );

    // Output byte with folded checksum on the final byte
    assign chk       = acc_reg ^ cur_byte;
    assign send_byte = (idx_reg == skrm_pkg::IDX_LAST)
                       ? (cur_byte | {4'h0, chk[7:4] ^ chk[3:0]}) : cur_byte;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load      = (state_reg == ST_SEND) && out_free;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        acc_next        = acc_reg;
        left_idle_next  = left_idle_reg;
        right_idle_next = right_idle_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next = skrm_pkg::IDX_FIRST;
                    acc_next = 8'h00;
                    if (is_packet)
                    begin
                        op_next.right     = (req_type == skrm_pkg::REQ_RIGHT);
                        op_next.clr_left  = (req_type == skrm_pkg::REQ_LEFT);
                        op_next.clr_right = (req_type == skrm_pkg::REQ_RIGHT);
                        op_next.add_en    = 1'b1;
                        op_next.button    = button;
                        op_next.keys      = key_bits;
                        op_next.dx        = delta_x;
                        op_next.dy        = delta_y;
                        op_next.dw        = delta_wheel;
                        if (req_type == skrm_pkg::REQ_RIGHT)
                        begin
                            right_idle_next = 21'd0;
                        end
                        else
                        begin
                            left_idle_next = 21'd0;
                        end
                        state_next = ST_UPD;
                    end
                    else if (is_tick)
                    begin
                        op_next.clr_left  = left_exp;
                        op_next.clr_right = right_exp;
                        op_next.add_en    = 1'b0;
                        op_next.button    = 1'b0;
                        left_idle_next    = left_exp ? 21'd0 : left_inc;
                        right_idle_next   = right_exp ? 21'd0 : right_inc;
                        if (left_exp || right_exp)
                        begin
                            state_next = ST_UPD;
                        end
                    end
                    else if (is_poll)
                    begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_UPD:
            begin
                idx_next = idx_reg + IW'(1);
                if (idx_reg == skrm_pkg::IDX_LAST)
                begin
                    idx_next   = skrm_pkg::IDX_FIRST;
                    state_next = ST_IDLE;
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    acc_next = acc_reg ^ cur_byte;
                    idx_next = idx_reg + IW'(1);
                    if (idx_reg == skrm_pkg::IDX_LAST)
                    begin
                        idx_next   = skrm_pkg::IDX_FIRST;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= skrm_pkg::IDX_FIRST;
            left_idle_reg  <= 21'd0;
            right_idle_reg <= 21'd0;
            limit_reg      <= skrm_pkg::IDLE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            left_idle_reg  <= left_idle_next;
            right_idle_reg <= right_idle_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Update report bytes; drop motion bytes once sent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < skrm_pkg::REPORT_LEN; i++)
            begin
                store_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (state_reg == ST_UPD)
            begin
                store_reg[idx_reg] <= alu_byte;
            end
            else if (load && (idx_reg >= skrm_pkg::BYTE_DX) && (idx_reg <= skrm_pkg::BYTE_WL))
            begin
                store_reg[idx_reg] <= 8'h00;
            end
        end
    end

    // Operation, checksum and output payload
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
        if (load)
        begin
            out_byte_reg <= send_byte;
            out_last_reg <= (idx_reg == skrm_pkg::IDX_LAST);
        end
    end

    assign out_valid   = out_valid_reg;
    assign report_byte = out_byte_reg;
    assign last        = out_last_reg;

endmodule

### rtl/skrm_byte_alu.sv
module skrm_byte_alu (
    input  skrm_pkg::alu_op_t                 op,
    input  logic [skrm_pkg::IDX_W-1:0]        idx,
    input  logic [7:0]                        cur,
    output logic [7:0]                        nxt
);

    logic [7:0] keep_l;
    logic [7:0] keep_r;
    logic [7:0] key_or;
    logic [7:0] btn_bit;

    // Masks for key bytes
    always_comb
    begin
        keep_l = 8'hFF;
        keep_r = 8'hFF;
        key_or = 8'h00;
        if (idx <= skrm_pkg::IDX_KEYEND)
        begin
            if (op.clr_left)
            begin
                keep_l = skrm_pkg::KEEP_LEFT[idx[2:0]];
            end
            if (op.clr_right)
            begin
                keep_r = skrm_pkg::KEEP_RIGHT[idx[2:0]];
            end
            if (op.add_en)
            begin
                key_or = skrm_pkg::key_byte(op.right, op.keys, idx[2:0]);
            end
        end
    end

    assign btn_bit = op.right ? skrm_pkg::BTN_RIGHT : skrm_pkg::BTN_LEFT;

    // Compute the new value of one report byte
    always_comb
    begin
        nxt = cur;
        case (idx) inside
            [skrm_pkg::IDX_FIRST:skrm_pkg::IDX_KEYEND]:
            begin
                nxt = (cur & keep_l & keep_r) | key_or;
            end
            skrm_pkg::BYTE_DX:
            begin
                if (op.add_en)
                begin
                    nxt = skrm_pkg::sat_add($signed(cur), op.dx);
                end
            end
            skrm_pkg::BYTE_DY:
            begin
                if (op.add_en)
                begin
                    nxt = skrm_pkg::sat_add($signed(cur), op.dy);
                end
            end
            skrm_pkg::BYTE_WR:
            begin
                if (op.add_en && op.right)
                begin
                    nxt = skrm_pkg::sat_add($signed(cur), op.dw);
                end
            end
            skrm_pkg::BYTE_WL:
            begin
                if (op.add_en && !op.right)
                begin
                    nxt = skrm_pkg::sat_add($signed(cur), op.dw);
                end
            end
            skrm_pkg::BYTE_BTN:
            begin
                nxt = cur & ~(op.clr_left ? skrm_pkg::BTN_LEFT : 8'h00)
                          & ~(op.clr_right ? skrm_pkg::BTN_RIGHT : 8'h00);
                if (op.add_en && op.button)
                begin
                    nxt = nxt | btn_bit;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule
